// ----- hdl/proximity_wall_follow_steering_top_assert.svh -----
// assertion macros for the wall-follow steering top level
// expects clk and arst_n in the scope of each use
`ifndef PROXIMITY_WALL_FOLLOW_STEERING_TOP_ASSERT_SVH
`define PROXIMITY_WALL_FOLLOW_STEERING_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define PWFS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pwfs same-cycle check failed");

// next-cycle implication, quiet during reset
`define PWFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pwfs next-cycle check failed");

`endif

// ----- hdl/pwfs_pkg.sv -----
// shared types, constants and weight tables for the wall-follow steering block
// no dependencies
package pwfs_pkg;

	localparam int SENSOR_COUNT = 8;
	localparam int CAL_FRAMES_DEF = 32;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int OFFSET_SHIFT = 5;
	localparam int FLOOR_SHIFT = 4;

	localparam int BIAS_W = 10;
	localparam int SPEED_W = 11;
	localparam int THRESH_W = 12;
	localparam int WEIGHT_W = 5;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_INDEX_W = 3;

	localparam logic ACTION_CAL = 1'b0;
	localparam logic ACTION_DRIVE = 1'b1;

	localparam logic SIDE_LEFT = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	localparam logic FOLLOW_SIDE_RST = SIDE_LEFT;
	localparam logic [BIAS_W-1:0] BASE_SPEED_RST = 10'd200;
	localparam logic [BIAS_W-1:0] MAX_SPEED_RST = 10'd800;
	localparam logic [THRESH_W-1:0] DETECT_THRESHOLD_RST = 12'd50;
	localparam logic [THRESH_W-1:0] CLOSE_THRESHOLD_RST = 12'd300;

	localparam int WALL_SENSOR_RIGHT = 2;
	localparam int WALL_SENSOR_LEFT = 5;
	localparam int OUTER_W = 10;

	localparam int BASE_LEFT_W [SENSOR_COUNT] = '{-10, -10, -5, 0, 0, 5, 10, 10};
	localparam int CUT_RIGHT_SIDE [SENSOR_COUNT] = '{0, 200, 600, 100, 0, 0, 0, 0};
	localparam int CUT_LEFT_SIDE [SENSOR_COUNT] = '{0, 0, 0, 0, 100, 600, 200, 0};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FOLLOW_SIDE,
		REG_BASE_SPEED,
		REG_MAX_SPEED,
		REG_DETECT_THRESHOLD,
		REG_CLOSE_THRESHOLD
	} cfg_reg_t;

	typedef struct packed {
		logic seen;
		logic close;
	} lane_flags_t;

	// left wheel weight; the right wheel always uses the negated weight
	function automatic int left_weight(input int lane, input logic side);
		int w;
		if (lane == 0 || lane == SENSOR_COUNT - 1) begin
			w = (side == SIDE_RIGHT) ? -OUTER_W : OUTER_W;
		end else begin
			w = BASE_LEFT_W[lane];
		end
		return w;
	endfunction

endpackage

// ----- hdl/pwfs_lane.sv -----
// one sensor lane: calibration sum, offset, distance and threshold flags
// depends on pwfs_pkg
module pwfs_lane #(
	parameter int SAMPLE_BITS = pwfs_pkg::SAMPLE_BITS_DEF,
	parameter int CAL_FRAMES = pwfs_pkg::CAL_FRAMES_DEF,
	parameter int DIST_W = pwfs_pkg::THRESH_W + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cal_en,
	input  logic                              cal_last,
	input  logic                              pipe_en,
	input  logic [SAMPLE_BITS-1:0]            sample,
	input  logic [pwfs_pkg::THRESH_W-1:0]     detect_threshold,
	input  logic [pwfs_pkg::THRESH_W-1:0]     close_threshold,
	output logic signed [DIST_W-1:0]          dist_s1,
	output pwfs_pkg::lane_flags_t             flags_s1
);
	import pwfs_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + $clog2(CAL_FRAMES);
	localparam logic [SUM_W-1:0] SAMPLE_MAX = SUM_W'((1 << SAMPLE_BITS) - 1);

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0] sum_shr;
	logic [SAMPLE_BITS-1:0] offset_q;
	logic [SAMPLE_BITS-1:0] offset_next;
	logic signed [DIST_W-1:0] dist_now;
	logic signed [DIST_W-1:0] detect_ext;
	logic signed [DIST_W-1:0] close_ext;

	always_comb begin
		sum_next = sum_q + SUM_W'(sample);
		sum_shr = sum_next >> OFFSET_SHIFT;
		// offsets saturate at the top of the sample range
		offset_next = (sum_shr > SAMPLE_MAX) ? SAMPLE_MAX[SAMPLE_BITS-1:0]
			: sum_shr[SAMPLE_BITS-1:0];
		dist_now = $signed({{(DIST_W-SAMPLE_BITS){1'b0}}, sample})
			- $signed({{(DIST_W-SAMPLE_BITS){1'b0}}, offset_q});
		detect_ext = $signed({{(DIST_W-THRESH_W){1'b0}}, detect_threshold});
		close_ext = $signed({{(DIST_W-THRESH_W){1'b0}}, close_threshold});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			offset_q <= '0;
		end else if (cal_en) begin
			if (cal_last) begin
				sum_q <= '0;
				offset_q <= offset_next;
			end else begin
				sum_q <= sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dist_s1 <= dist_now;
			flags_s1.seen <= (dist_now > detect_ext);
			flags_s1.close <= (dist_now > close_ext);
		end
	end

endmodule

// ----- hdl/pwfs_merge.sv -----
// merge stage: near-wall cuts, weighted sum over all lanes, bias and clamp
// depends on pwfs_pkg
module pwfs_merge #(
	parameter int DIST_W = pwfs_pkg::THRESH_W + 2
) (
	input  logic                                clk,
	input  logic                                pipe_en,
	input  logic                                follow_side,
	input  logic [pwfs_pkg::BIAS_W-1:0]         base_speed,
	input  logic [pwfs_pkg::BIAS_W-1:0]         max_speed,
	input  logic signed [DIST_W-1:0]            dist_s1 [pwfs_pkg::SENSOR_COUNT],
	input  pwfs_pkg::lane_flags_t               flags_s1 [pwfs_pkg::SENSOR_COUNT],
	output logic signed [pwfs_pkg::SPEED_W-1:0] left_speed,
	output logic signed [pwfs_pkg::SPEED_W-1:0] right_speed,
	output logic                                no_wall
);
	import pwfs_pkg::*;

	localparam int PROD_W = DIST_W + WEIGHT_W;
	localparam int SUM_W = DIST_W + 8;
	localparam int TOT_W = SUM_W + 1;

	logic cut_on;
	logic seen;
	logic signed [DIST_W-1:0] adj [SENSOR_COUNT];
	logic signed [DIST_W-1:0] shr [SENSOR_COUNT];
	logic signed [WEIGHT_W-1:0] wgt [SENSOR_COUNT];
	logic signed [PROD_W-1:0] prod [SENSOR_COUNT];
	logic signed [SUM_W-1:0] acc;
	logic signed [SUM_W-1:0] sum_s2;
	logic seen_s2;
	logic signed [TOT_W-1:0] bias_ext;
	logic signed [TOT_W-1:0] lim_ext;
	logic signed [TOT_W-1:0] lw;
	logic signed [TOT_W-1:0] rw;
	logic signed [TOT_W-1:0] lw_c;
	logic signed [TOT_W-1:0] rw_c;

	always_comb begin
		cut_on = (follow_side == SIDE_RIGHT) ? flags_s1[WALL_SENSOR_RIGHT].close
			: flags_s1[WALL_SENSOR_LEFT].close;
		seen = 1'b0;
		acc = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			seen = seen | flags_s1[i].seen;
			adj[i] = dist_s1[i];
			if (cut_on) begin
				adj[i] = dist_s1[i] - ((follow_side == SIDE_RIGHT)
					? DIST_W'(CUT_RIGHT_SIDE[i]) : DIST_W'(CUT_LEFT_SIDE[i]));
			end
			// arithmetic shift rounds toward minus infinity
			shr[i] = adj[i] >>> FLOOR_SHIFT;
			wgt[i] = WEIGHT_W'(left_weight(i, follow_side));
			prod[i] = shr[i] * wgt[i];
			acc = acc + SUM_W'(prod[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			sum_s2 <= seen ? acc : '0;
			seen_s2 <= seen;
		end
	end

	// right wheel weights are the negated left ones
	always_comb begin
		bias_ext = $signed({{(TOT_W-BIAS_W){1'b0}}, base_speed});
		lim_ext = $signed({{(TOT_W-BIAS_W){1'b0}}, max_speed});
		lw = bias_ext + TOT_W'(sum_s2);
		rw = bias_ext - TOT_W'(sum_s2);
		lw_c = lw;
		if (lw > lim_ext) begin
			lw_c = lim_ext;
		end else if (lw < -lim_ext) begin
			lw_c = -lim_ext;
		end
		rw_c = rw;
		if (rw > lim_ext) begin
			rw_c = lim_ext;
		end else if (rw < -lim_ext) begin
			rw_c = -lim_ext;
		end
		left_speed = lw_c[SPEED_W-1:0];
		right_speed = rw_c[SPEED_W-1:0];
		no_wall = !seen_s2;
	end

endmodule

// ----- hdl/proximity_wall_follow_steering_top.sv -----
// top level of the wall-follow steering block: config registers, lanes, merge, output
// depends on pwfs_pkg, pwfs_lane, pwfs_merge and the assertion macro header
//
// Usage: the input channel (in_valid/in_ready) carries one frame of eight
// proximity readings and an action bit. Calibration frames (action 0) are
// summed per sensor; every CAL_FRAMES-th one loads the offsets and reports
// calibration_done. Drive frames (action 1) produce two clamped wheel speeds.
// Every frame yields exactly one result transaction on out_valid/out_ready.
// Throughput: one frame per cycle unless a result is held by out_ready
// low; the lanes, the weighted-sum register and the output register form
// a three-stage pipeline that moves as a whole.
// Calibration state is updated at acceptance, so the next frame already
// sees fresh offsets.
// Stall: while a result waits on out_ready low, in_ready is low and the whole
// pipeline holds. Reset clears the config registers to their defaults, the
// sums, offsets and frame count to zero, and empties the pipeline.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once and are
// meant to be done while no frame is in flight.
module proximity_wall_follow_steering_top #(
	parameter int CAL_FRAMES = pwfs_pkg::CAL_FRAMES_DEF,
	parameter int SAMPLE_BITS = pwfs_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pwfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pwfs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic [SAMPLE_BITS-1:0]              prox_0,
	input  logic [SAMPLE_BITS-1:0]              prox_1,
	input  logic [SAMPLE_BITS-1:0]              prox_2,
	input  logic [SAMPLE_BITS-1:0]              prox_3,
	input  logic [SAMPLE_BITS-1:0]              prox_4,
	input  logic [SAMPLE_BITS-1:0]              prox_5,
	input  logic [SAMPLE_BITS-1:0]              prox_6,
	input  logic [SAMPLE_BITS-1:0]              prox_7,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pwfs_pkg::SPEED_W-1:0] left_speed,
	output logic signed [pwfs_pkg::SPEED_W-1:0] right_speed,
	output logic                                calibrating,
	output logic                                calibration_done,
	output logic                                no_wall
);
	import pwfs_pkg::*;

	localparam int DIST_W = ((SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W) + 2;
	localparam int CNT_W = $clog2(CAL_FRAMES);
	localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_FRAMES - 1);

	logic follow_side_q;
	logic [BIAS_W-1:0] base_speed_q;
	logic [BIAS_W-1:0] max_speed_q;
	logic [THRESH_W-1:0] detect_threshold_q;
	logic [THRESH_W-1:0] close_threshold_q;

	logic [CNT_W-1:0] cal_count_q;
	logic advance;
	logic accept;
	logic cal_en;
	logic cal_last;

	logic v1_q;
	logic v2_q;
	logic out_valid_q;
	logic action_s1;
	logic action_s2;
	logic done_s1;
	logic done_s2;

	logic [SAMPLE_BITS-1:0] prox [SENSOR_COUNT];
	logic signed [DIST_W-1:0] dist_s1 [SENSOR_COUNT];
	lane_flags_t flags_s1 [SENSOR_COUNT];

	logic signed [SPEED_W-1:0] merge_left;
	logic signed [SPEED_W-1:0] merge_right;
	logic merge_no_wall;

	logic signed [SPEED_W-1:0] left_speed_q;
	logic signed [SPEED_W-1:0] right_speed_q;
	logic calibrating_q;
	logic calibration_done_q;
	logic no_wall_q;

	assign prox[0] = prox_0;
	assign prox[1] = prox_1;
	assign prox[2] = prox_2;
	assign prox[3] = prox_3;
	assign prox[4] = prox_4;
	assign prox[5] = prox_5;
	assign prox[6] = prox_6;
	assign prox[7] = prox_7;

	// whole pipeline moves unless a finished result is stuck at the output
	assign advance = !out_valid_q || out_ready;
	assign in_ready = advance;
	assign accept = in_valid && in_ready;
	assign cal_en = accept && (action == ACTION_CAL);
	assign cal_last = (cal_count_q == CAL_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			follow_side_q <= FOLLOW_SIDE_RST;
			base_speed_q <= BASE_SPEED_RST;
			max_speed_q <= MAX_SPEED_RST;
			detect_threshold_q <= DETECT_THRESHOLD_RST;
			close_threshold_q <= CLOSE_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FOLLOW_SIDE: follow_side_q <= cfg_data[0];
				REG_BASE_SPEED: base_speed_q <= cfg_data[BIAS_W-1:0];
				REG_MAX_SPEED: max_speed_q <= cfg_data[BIAS_W-1:0];
				REG_DETECT_THRESHOLD: detect_threshold_q <= cfg_data[THRESH_W-1:0];
				REG_CLOSE_THRESHOLD: close_threshold_q <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_count_q <= '0;
		end else if (cal_en) begin
			cal_count_q <= cal_last ? '0 : cal_count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v1_q <= accept;
			v2_q <= v1_q;
			out_valid_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_s1 <= action;
			done_s1 <= cal_en && cal_last;
			action_s2 <= action_s1;
			done_s2 <= done_s1;
			if (action_s2 == ACTION_DRIVE) begin
				left_speed_q <= merge_left;
				right_speed_q <= merge_right;
				no_wall_q <= merge_no_wall;
				calibrating_q <= 1'b0;
				calibration_done_q <= 1'b0;
			end else begin
				left_speed_q <= '0;
				right_speed_q <= '0;
				no_wall_q <= 1'b0;
				calibrating_q <= 1'b1;
				calibration_done_q <= done_s2;
			end
		end
	end

	for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
		pwfs_lane #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.CAL_FRAMES(CAL_FRAMES),
			.DIST_W(DIST_W)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.cal_en(cal_en),
			.cal_last(cal_last),
			.pipe_en(advance),
			.sample(prox[g]),
			.detect_threshold(detect_threshold_q),
			.close_threshold(close_threshold_q),
			.dist_s1(dist_s1[g]),
			.flags_s1(flags_s1[g])
		);
	end

	pwfs_merge #(
		.DIST_W(DIST_W)
	) u_merge (
		.clk(clk),
		.pipe_en(advance),
		.follow_side(follow_side_q),
		.base_speed(base_speed_q),
		.max_speed(max_speed_q),
		.dist_s1(dist_s1),
		.flags_s1(flags_s1),
		.left_speed(merge_left),
		.right_speed(merge_right),
		.no_wall(merge_no_wall)
	);

	assign out_valid = out_valid_q;
	assign left_speed = left_speed_q;
	assign right_speed = right_speed_q;
	assign calibrating = calibrating_q;
	assign calibration_done = calibration_done_q;
	assign no_wall = no_wall_q;

`include "proximity_wall_follow_steering_top_assert.svh"

	`PWFS_ASSERT_IMP(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
	`PWFS_ASSERT_IMP(a_cal_result_quiet, out_valid && calibrating,
		left_speed == '0 && right_speed == '0 && !no_wall)
	`PWFS_ASSERT_IMP(a_done_is_cal, out_valid && calibration_done, calibrating)
	`PWFS_ASSERT_NEXT(a_count_wraps, cal_en && cal_last, cal_count_q == '0)

endmodule

// ----- dv/tb_proximity_wall_follow_steering_top.sv -----
// self-checking testbench for proximity_wall_follow_steering_top: a queue-fed driver,
// a monitor checking against an in-bench steering predictor, phased config and idling
// depends on pwfs_pkg and the RTL of the steering block
module tb_proximity_wall_follow_steering_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pwfs_pkg::*;

	localparam int CAL_FRAMES = CAL_FRAMES_DEF;
	localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
	localparam int SAMPLE_TOP = (1 << SAMPLE_BITS) - 1;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 230;
	localparam int HOLD_CYCLES = 300;
	localparam int RIGHT_WALL_LANE = 2;
	localparam int LEFT_WALL_LANE = 5;
	localparam int LANE_W [SENSOR_COUNT] = '{-10, -10, -5, 0, 0, 5, 10, 10};
	localparam int RIGHT_CUT [SENSOR_COUNT] = '{0, 200, 600, 100, 0, 0, 0, 0};
	localparam int LEFT_CUT [SENSOR_COUNT] = '{0, 0, 0, 0, 100, 600, 200, 0};

	typedef struct packed {
		logic action;
		logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] prox;
	} frame_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
		logic calibrating;
		logic calibration_done;
		logic no_wall;
	} steer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACTION_CAL;
	logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] prox_bus = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SPEED_W-1:0] left_speed;
	logic signed [SPEED_W-1:0] right_speed;
	logic calibrating;
	logic calibration_done;
	logic no_wall;

	// predictor copy of registers and calibration state
	logic mdl_side = FOLLOW_SIDE_RST;
	logic [BIAS_W-1:0] mdl_bias = BASE_SPEED_RST;
	logic [BIAS_W-1:0] mdl_max = MAX_SPEED_RST;
	logic [THRESH_W-1:0] mdl_detect = DETECT_THRESHOLD_RST;
	logic [THRESH_W-1:0] mdl_close = CLOSE_THRESHOLD_RST;
	logic [16:0] cal_sum [SENSOR_COUNT] = '{default: '0};
	logic [SAMPLE_BITS-1:0] cal_offset [SENSOR_COUNT] = '{default: '0};
	int cal_count = 0;

	frame_t frame_q [$];
	steer_t steer_q [$];
	frame_t offered;
	steer_t want;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic rx_hold = 1'b0;
	int err_count = 0;

	proximity_wall_follow_steering_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.prox_0(prox_bus[0]),
		.prox_1(prox_bus[1]),
		.prox_2(prox_bus[2]),
		.prox_3(prox_bus[3]),
		.prox_4(prox_bus[4]),
		.prox_5(prox_bus[5]),
		.prox_6(prox_bus[6]),
		.prox_7(prox_bus[7]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_speed(left_speed),
		.right_speed(right_speed),
		.calibrating(calibrating),
		.calibration_done(calibration_done),
		.no_wall(no_wall)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic steer_t predict_steering(input frame_t f);
		steer_t r;
		int dist_v [SENSOR_COUNT];
		int w;
		int s;
		int lw;
		int rw;
		int lim;
		logic seen;
		logic close;
		r = '0;
		if (f.action == ACTION_CAL) begin
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				cal_sum[i] = cal_sum[i] + 17'(f.prox[i]);
			end
			cal_count++;
			r.calibrating = 1'b1;
			if (cal_count >= CAL_FRAMES) begin
				for (int i = 0; i < SENSOR_COUNT; i++) begin
					s = int'(cal_sum[i] >> OFFSET_SHIFT);
					cal_offset[i] = (s > SAMPLE_TOP) ? SAMPLE_BITS'(SAMPLE_TOP) : SAMPLE_BITS'(s);
					cal_sum[i] = '0;
				end
				cal_count = 0;
				r.calibration_done = 1'b1;
			end
			return r;
		end
		seen = 1'b0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			dist_v[i] = int'(f.prox[i]) - int'(cal_offset[i]);
			if (dist_v[i] > int'(mdl_detect))
				seen = 1'b1;
		end
		lw = int'(mdl_bias);
		rw = int'(mdl_bias);
		if (seen) begin
			if (mdl_side == SIDE_RIGHT)
				close = dist_v[RIGHT_WALL_LANE] > int'(mdl_close);
			else
				close = dist_v[LEFT_WALL_LANE] > int'(mdl_close);
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				if (close)
					dist_v[i] -= (mdl_side == SIDE_RIGHT) ? RIGHT_CUT[i] : LEFT_CUT[i];
				// outer lanes steer toward the wall side; right wheel mirrors the left
				if (i == 0 || i == SENSOR_COUNT - 1)
					w = (mdl_side == SIDE_RIGHT) ? -10 : 10;
				else
					w = LANE_W[i];
				s = dist_v[i] >>> FLOOR_SHIFT;
				lw += w * s;
				rw -= w * s;
			end
		end
		lim = int'(mdl_max);
		if (lw > lim) lw = lim;
		if (lw < -lim) lw = -lim;
		if (rw > lim) rw = lim;
		if (rw < -lim) rw = -lim;
		r.left_speed = lw[SPEED_W-1:0];
		r.right_speed = rw[SPEED_W-1:0];
		r.no_wall = !seen;
		return r;
	endfunction

	function automatic frame_t uniform_frame(input logic act, input int val);
		frame_t f;
		f.action = act;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			f.prox[i] = SAMPLE_BITS'(val);
		end
		return f;
	endfunction

	function automatic frame_t rand_frame(input logic act, input logic wide);
		frame_t f;
		logic quiet;
		int sel;
		f.action = act;
		quiet = ($urandom_range(3) == 0);
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			sel = $urandom_range(9);
			if (act == ACTION_CAL)
				f.prox[i] = wide ? SAMPLE_BITS'($urandom_range(SAMPLE_TOP))
					: SAMPLE_BITS'($urandom_range(255));
			else if (quiet)
				f.prox[i] = SAMPLE_BITS'($urandom_range(250));
			else if (sel < 3)
				f.prox[i] = SAMPLE_BITS'($urandom_range(150));
			else if (sel < 6)
				f.prox[i] = SAMPLE_BITS'($urandom_range(1500, 150));
			else if (sel < 8)
				f.prox[i] = SAMPLE_BITS'($urandom_range(SAMPLE_TOP));
			else if (sel == 8)
				f.prox[i] = '0;
			else
				f.prox[i] = SAMPLE_BITS'(SAMPLE_TOP);
		end
		return f;
	endfunction

	task automatic check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			err_count++;
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
		end
	endtask

	task automatic put_reg(input cfg_reg_t idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
	endtask

	task automatic load_config(input logic side, input int bias, input int max_v,
			input int detect, input int close);
		@(posedge clk);
		put_reg(REG_FOLLOW_SIDE, int'(side));
		@(posedge clk);
		put_reg(REG_BASE_SPEED, bias);
		@(posedge clk);
		put_reg(REG_MAX_SPEED, max_v);
		@(posedge clk);
		put_reg(REG_DETECT_THRESHOLD, detect);
		@(posedge clk);
		put_reg(REG_CLOSE_THRESHOLD, close);
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_side = side;
		mdl_bias = BIAS_W'(bias);
		mdl_max = BIAS_W'(max_v);
		mdl_detect = THRESH_W'(detect);
		mdl_close = THRESH_W'(close);
	endtask

	// block until every queued frame went in and every result came out
	task automatic wait_drained();
		do @(negedge clk);
		while (frame_q.size() != 0 || in_valid || steer_q.size() != 0);
	endtask

	// driver: offer queued frames, predict each transaction as it is accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				steer_q.push_back(predict_steering(offered));
			if (!in_valid || in_ready) begin
				if (frame_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					offered = frame_q.pop_front();
					in_valid <= 1'b1;
					action <= offered.action;
					prox_bus <= offered.prox;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (steer_q.size() == 0) begin
				err_count++;
				$error("result transaction with no prediction pending");
			end else begin
				want = steer_q.pop_front();
				check_field("left_speed", int'(want.left_speed), int'(left_speed));
				check_field("right_speed", int'(want.right_speed), int'(right_speed));
				check_field("calibrating", int'(want.calibrating), int'(calibrating));
				check_field("calibration_done", int'(want.calibration_done),
					int'(calibration_done));
				check_field("no_wall", int'(want.no_wall), int'(no_wall));
			end
		end
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	initial begin
		frame_t f;
		int n;
		int pick;
		logic wide;
		logic paused;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p)
				0: load_config(SIDE_LEFT, 200, 800, 50, 300);
				1: load_config(SIDE_RIGHT, 0, 1023, 0, 0);
				2: load_config(SIDE_LEFT, 1023, 0, 4095, 4095);
				3: load_config(SIDE_RIGHT, 1023, 1023, 0, 4095);
				default: load_config(logic'($urandom_range(1)), $urandom_range(1023),
					$urandom_range(1023), $urandom_range(400), $urandom_range(1000));
			endcase
			@(negedge clk);
			case (p % 4)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 82; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 82; end
				default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
			endcase
			if (p == 0) begin
				// raw readings as distances before any calibration
				f = uniform_frame(ACTION_DRIVE, 0);
				frame_q.push_back(f);
				frame_q.push_back(uniform_frame(ACTION_DRIVE, SAMPLE_TOP));
				frame_q.push_back(uniform_frame(ACTION_DRIVE, 50));
				f.prox[3] = SAMPLE_BITS'(51);
				frame_q.push_back(f);
				f = uniform_frame(ACTION_DRIVE, 0);
				f.prox[LEFT_WALL_LANE] = SAMPLE_BITS'(301);
				frame_q.push_back(f);
				f.prox[LEFT_WALL_LANE] = SAMPLE_BITS'(300);
				frame_q.push_back(f);
				f = uniform_frame(ACTION_DRIVE, 0);
				f.prox[RIGHT_WALL_LANE] = SAMPLE_BITS'(SAMPLE_TOP);
				frame_q.push_back(f);
				f = uniform_frame(ACTION_DRIVE, 0);
				f.prox[0] = SAMPLE_BITS'(SAMPLE_TOP);
				frame_q.push_back(f);
				f = uniform_frame(ACTION_DRIVE, 0);
				f.prox[SENSOR_COUNT-1] = SAMPLE_BITS'(SAMPLE_TOP);
				frame_q.push_back(f);
				f = uniform_frame(ACTION_DRIVE, 0);
				f.prox[1] = SAMPLE_BITS'(17);
				f.prox[6] = SAMPLE_BITS'(4000);
				frame_q.push_back(f);
				frame_q.push_back(uniform_frame(ACTION_CAL, SAMPLE_TOP));
				frame_q.push_back(uniform_frame(ACTION_CAL, 0));
				// drive in the middle of a calibration run leaves the sums alone
				frame_q.push_back(uniform_frame(ACTION_DRIVE, 'haaa));
				frame_q.push_back(uniform_frame(ACTION_CAL, 'h555));
				frame_q.push_back(uniform_frame(ACTION_DRIVE, 'h555));
				frame_q.push_back(uniform_frame(ACTION_DRIVE, 'haaa));
			end
			if (p == 4) begin
				fork
					begin
						rx_hold <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						rx_hold <= 1'b0;
					end
				join_none
			end
			n = 0;
			paused = 1'b0;
			while (n < PHASE_ITEMS) begin
				if (p == 5 && !paused && n >= PHASE_ITEMS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				pick = $urandom_range(99);
				if (pick < 2) begin
					// full calibration run with mostly low readings
					wide = ($urandom_range(5) == 0);
					repeat (CAL_FRAMES) frame_q.push_back(rand_frame(ACTION_CAL, wide));
					n += CAL_FRAMES;
				end else if (pick < 12) begin
					frame_q.push_back(rand_frame(ACTION_CAL, $urandom_range(5) == 0));
					n++;
				end else begin
					frame_q.push_back(rand_frame(ACTION_DRIVE, 1'b0));
					n++;
				end
			end
		end
		wait_drained();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- proximity_wall_follow_steering_top.f -----
+incdir+hdl
hdl/pwfs_pkg.sv
hdl/pwfs_lane.sv
hdl/pwfs_merge.sv
hdl/proximity_wall_follow_steering_top.sv
dv/tb_proximity_wall_follow_steering_top.sv
